@@ src/assert_macros.svh @@
// Assertion macros used by the checker module of the position tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside of reset.
`define PPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ppt_pkg.sv @@
// Shared constants, types and width functions of the position tracker.
`default_nettype none
package ppt_pkg;

  localparam int TRAJ_DEPTH_DEF  = 1024;
  localparam int DRIVE_LIMIT_DEF = 100;
  localparam int PCT_FULL        = 100;
  localparam int PERIOD_SPAN     = 65536;

  // Reciprocal of PCT_FULL scaled by 2**RECIP_SHIFT, rounded up.
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 26;
  localparam logic [RECIP_W-1:0] RECIP_PCT = 26'd42949673;

  localparam int IN_TDATA_W = 48;
  localparam int SLOT_W     = 10;
  localparam int POS_W      = 16;

  localparam logic [1:0] MODE_HOLD  = 2'd1;
  localparam logic [1:0] MODE_TRACK = 2'd2;

  localparam logic [2:0] REG_GAIN_PROP    = 3'd0;
  localparam logic [2:0] REG_GAIN_INTEG   = 3'd1;
  localparam logic [2:0] REG_GAIN_DERIV   = 3'd2;
  localparam logic [2:0] REG_HOLD_TARGET  = 3'd3;
  localparam logic [2:0] REG_RUN_MODE     = 3'd4;
  localparam logic [2:0] REG_TRACK_LENGTH = 3'd5;
  localparam logic [2:0] REG_PWM_PERIOD   = 3'd6;

  typedef struct packed {
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic [15:0]        period;
  } pid_cfg_t;

  typedef struct packed {
    logic                    start;
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] ref_pos;
  } pid_req_t;

  function automatic int mag_width(int limit);
    return $clog2(limit + 1);
  endfunction

  function automatic int cmp_width(int limit);
    return $clog2((PERIOD_SPAN * limit) / PCT_FULL + 1);
  endfunction

  function automatic int out_width(int limit);
    return 2 * mag_width(limit) + 2 + cmp_width(limit) + 2 * POS_W;
  endfunction

endpackage
`default_nettype wire

@@ src/ppt_traj_mem.sv @@
// Trajectory sample memory with one write port and a registered read port.
`default_nettype none
module ppt_traj_mem #(
  parameter int DEPTH = ppt_pkg::TRAJ_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [AW-1:0]                   wr_addr,
  input  logic signed [ppt_pkg::POS_W-1:0] wr_data,
  input  logic                            rd_en,
  input  logic [AW-1:0]                   rd_addr,
  output logic signed [ppt_pkg::POS_W-1:0] rd_data
);

  logic signed [ppt_pkg::POS_W-1:0] mem [DEPTH];
  logic signed [ppt_pkg::POS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ src/ppt_pid_unit.sv @@
// PID arithmetic sequencer with a shared multiplier and the integrator state.
`default_nettype none
module ppt_pid_unit #(
  parameter int DRIVE_LIMIT = ppt_pkg::DRIVE_LIMIT_DEF,
  localparam int MAG_W = ppt_pkg::mag_width(DRIVE_LIMIT),
  localparam int DRV_W = MAG_W + 1,
  localparam int CMP_W = ppt_pkg::cmp_width(DRIVE_LIMIT)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ppt_pkg::pid_req_t        req,
  input  ppt_pkg::pid_cfg_t        cfg,
  input  logic                     clear_sum,
  output logic                     done,
  output logic signed [DRV_W-1:0]  drive,
  output logic                     direction,
  output logic [MAG_W-1:0]         magnitude,
  output logic [CMP_W-1:0]         compare
);

  localparam int ACC_W = 50;
  localparam int XW    = 17 + MAG_W;
  localparam int DPW   = XW + ppt_pkg::RECIP_W;
  localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(DRIVE_LIMIT);
  localparam logic signed [ACC_W-1:0] LIM_NEG = -LIM_POS;

  typedef enum logic [9:0] {
    P_IDLE = 10'b00_0000_0001,
    P_ERR  = 10'b00_0000_0010,
    P_M0   = 10'b00_0000_0100,
    P_M1   = 10'b00_0000_1000,
    P_M2   = 10'b00_0001_0000,
    P_ACC  = 10'b00_0010_0000,
    P_DRV  = 10'b00_0100_0000,
    P_CMP  = 10'b00_1000_0000,
    P_DIV  = 10'b01_0000_0000,
    P_DONE = 10'b10_0000_0000
  } pid_state_t;

  pid_state_t state_r, state_nxt;

  logic signed [31:0]      error_sum_r;
  logic signed [16:0]      last_error_r;
  logic signed [16:0]      err_r;
  logic signed [17:0]      diff_r;
  logic signed [31:0]      sum_r;
  logic signed [47:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [DRV_W-1:0] drive_r;
  logic [MAG_W-1:0]        mag_r;
  logic [XW-1:0]           x_r;
  logic [CMP_W-1:0]        cmp_r;

  logic signed [32:0]      sum_wide;
  logic signed [31:0]      sum_sat;
  logic signed [15:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic signed [47:0]      mul_p;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_c;
  logic signed [ACC_W-1:0] acc_abs;
  logic [16:0]             per1;
  logic [DPW-1:0]          dprod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      P_IDLE: if (req.start) state_nxt = P_ERR;
      P_ERR:  state_nxt = P_M0;
      P_M0:   state_nxt = P_M1;
      P_M1:   state_nxt = P_M2;
      P_M2:   state_nxt = P_ACC;
      P_ACC:  state_nxt = P_DRV;
      P_DRV:  state_nxt = P_CMP;
      P_CMP:  state_nxt = P_DIV;
      P_DIV:  state_nxt = P_DONE;
      P_DONE: state_nxt = P_IDLE;
      default: state_nxt = P_IDLE;
    endcase
  end

  assign sum_wide = {error_sum_r[31], error_sum_r} + {{16{err_r[16]}}, err_r};
  always_comb begin
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  always_comb begin
    case (state_r)
      P_M1: begin
        mul_a = cfg.kd;
        mul_b = {{14{diff_r[17]}}, diff_r};
      end
      P_M2: begin
        mul_a = cfg.ki;
        mul_b = sum_r;
      end
      default: begin
        mul_a = cfg.kp;
        mul_b = {{15{err_r[16]}}, err_r};
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {{(ACC_W-48){prod_r[47]}}, prod_r};

  // Division by 256 that truncates toward zero, then the drive clamp.
  assign acc_rnd = acc_r + $signed({{(ACC_W-8){1'b0}}, {8{acc_r[ACC_W-1]}}});
  assign acc_q   = acc_rnd >>> 8;
  always_comb begin
    if (acc_q >= LIM_POS) begin
      acc_c = LIM_POS;
    end else if (acc_q <= LIM_NEG) begin
      acc_c = LIM_NEG;
    end else begin
      acc_c = acc_q;
    end
  end
  assign acc_abs = acc_c[ACC_W-1] ? -acc_c : acc_c;

  assign per1  = {1'b0, cfg.period} + 17'd1;
  assign dprod = DPW'(x_r) * DPW'(ppt_pkg::RECIP_PCT);

  always_ff @(posedge clk) begin
    case (state_r)
      P_IDLE: begin
        if (req.start) begin
          err_r <= {req.pos[15], req.pos} - {req.ref_pos[15], req.ref_pos};
        end
      end
      P_ERR: begin
        sum_r  <= sum_sat;
        diff_r <= {last_error_r[16], last_error_r} - {err_r[16], err_r};
      end
      P_M0: begin
        prod_r <= mul_p;
      end
      P_M1: begin
        prod_r <= mul_p;
        acc_r  <= prod_ext;
      end
      P_M2: begin
        prod_r <= mul_p;
        acc_r  <= acc_r + prod_ext;
      end
      P_ACC: begin
        acc_r <= acc_r + prod_ext;
      end
      P_DRV: begin
        drive_r <= DRV_W'(acc_c);
        mag_r   <= MAG_W'(acc_abs);
      end
      P_CMP: begin
        x_r <= XW'(per1) * XW'(mag_r);
      end
      P_DIV: begin
        cmp_r <= CMP_W'(dprod >> ppt_pkg::RECIP_SHIFT);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else if (clear_sum) begin
      error_sum_r <= '0;
    end else if (state_r == P_ERR) begin
      error_sum_r  <= sum_sat;
      last_error_r <= err_r;
    end
  end

  assign done      = (state_r == P_DONE);
  assign drive     = drive_r;
  assign direction = drive_r[DRV_W-1];
  assign magnitude = mag_r;
  assign compare   = cmp_r;

endmodule
`default_nettype wire

@@ src/pid_position_tracker.sv @@
// Top level of the PID position tracker: request sequencing, registers, output stage.
//
// Input channel (in_*): one request per item. in_tuser selects the kind: 0 is a
// control tick that uses the encoder count, 1 loads one trajectory sample.
// Configuration channel (cfg_*): cfg_index selects the register, cfg_data
// carries the value; cfg_ready is always high. Writing run_mode clears the
// error sum and the track walk.
// Result channel (out_*): one result for each tick in hold mode and each
// track-mode tick that still has a sample; other requests give none.
// Sequence: a producing tick goes through the error step, three passes through
// the shared gain multiplier, the drive clamp and the two PWM multiply steps
// before its result shows; in_tready is low meanwhile.
// Loads and ticks without a result leave in_tready high.
// A result waits in the output register while out_tready is low, and further
// requests are still accepted; a second result holds the sequencer until the
// register is taken.
// Reset clears control state, settings, the error sum, previous error and walk.
// Trajectory memory contents are undefined until loaded; there is no clearing.
`default_nettype none
module pid_position_tracker #(
  parameter int TRAJ_DEPTH  = ppt_pkg::TRAJ_DEPTH_DEF,
  parameter int DRIVE_LIMIT = ppt_pkg::DRIVE_LIMIT_DEF,
  localparam int OUT_W       = ppt_pkg::out_width(DRIVE_LIMIT),
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // encoder_count, sample_slot, sample_value
  input  logic [ppt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // drive_command, drive_direction, drive_magnitude, compare_value,
  // reference_used, position_echo
  output logic [OUT_TDATA_W-1:0]          out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [2:0]                      cfg_index,
  input  logic [15:0]                     cfg_data
);

  localparam int AW    = $clog2(TRAJ_DEPTH);
  localparam int MAG_W = ppt_pkg::mag_width(DRIVE_LIMIT);
  localparam int DRV_W = MAG_W + 1;
  localparam int CMP_W = ppt_pkg::cmp_width(DRIVE_LIMIT);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_REF  = 4'b0010,
    S_PID  = 4'b0100,
    S_OUT  = 4'b1000
  } top_state_t;

  top_state_t state_r, state_nxt;

  ppt_pkg::pid_cfg_t                 pid_cfg_r;
  logic signed [15:0]                hold_target_r;
  logic [1:0]                        run_mode_r;
  logic [10:0]                       track_length_r;
  logic [10:0]                       track_pos_r;
  logic                              track_done_r;
  logic signed [ppt_pkg::POS_W-1:0]  pos_r;
  logic signed [ppt_pkg::POS_W-1:0]  ref_r;
  logic                              out_tvalid_r;
  logic [OUT_TDATA_W-1:0]            out_tdata_r;

  logic                              in_acc;
  logic                              cfg_acc;
  logic                              is_tick;
  logic                              is_load;
  logic                              walk_end;
  logic                              track_go;
  logic                              slot_ok;
  logic signed [ppt_pkg::POS_W-1:0]  enc_in;
  logic [ppt_pkg::SLOT_W-1:0]        slot_in;
  logic signed [ppt_pkg::POS_W-1:0]  value_in;
  logic signed [ppt_pkg::POS_W-1:0]  mem_rdata;
  logic signed [ppt_pkg::POS_W-1:0]  ref_now;
  logic                              out_free;
  logic                              out_load;

  ppt_pkg::pid_req_t                 pid_req;
  logic                              pid_done;
  logic signed [DRV_W-1:0]           pid_drive;
  logic                              pid_dir;
  logic [MAG_W-1:0]                  pid_mag;
  logic [CMP_W-1:0]                  pid_cmp;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign is_load   = in_acc && in_tuser;
  assign is_tick   = in_acc && !in_tuser;

  assign enc_in   = in_tdata[15:0];
  assign slot_in  = in_tdata[25:16];
  assign value_in = in_tdata[41:26];

  assign slot_ok  = (32'(slot_in) < TRAJ_DEPTH);
  assign walk_end = (32'(track_pos_r) >= 32'(track_length_r)) ||
                    (32'(track_pos_r) >= TRAJ_DEPTH);
  assign track_go = is_tick && (run_mode_r == ppt_pkg::MODE_TRACK) &&
                    !track_done_r && !walk_end;

  ppt_traj_mem #(.DEPTH(TRAJ_DEPTH)) u_traj_mem (
    .clk     (clk),
    .wr_en   (is_load && slot_ok),
    .wr_addr (AW'(slot_in)),
    .wr_data (value_in),
    .rd_en   (track_go),
    .rd_addr (AW'(track_pos_r)),
    .rd_data (mem_rdata)
  );

  assign ref_now = (run_mode_r == ppt_pkg::MODE_TRACK) ? mem_rdata : hold_target_r;

  assign pid_req.start   = (state_r == S_REF);
  assign pid_req.pos     = pos_r;
  assign pid_req.ref_pos = ref_now;

  ppt_pid_unit #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_pid_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (pid_req),
    .cfg       (pid_cfg_r),
    .clear_sum (cfg_acc && (cfg_index == ppt_pkg::REG_RUN_MODE)),
    .done      (pid_done),
    .drive     (pid_drive),
    .direction (pid_dir),
    .magnitude (pid_mag),
    .compare   (pid_cmp)
  );

  assign out_free = !out_tvalid_r || out_tready;
  assign out_load = out_free && ((state_r == S_OUT) || ((state_r == S_PID) && pid_done));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if ((is_tick && (run_mode_r == ppt_pkg::MODE_HOLD)) || track_go) begin
          state_nxt = S_REF;
        end
      end
      S_REF: state_nxt = S_PID;
      S_PID: begin
        if (pid_done) begin
          state_nxt = out_free ? S_IDLE : S_OUT;
        end
      end
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      pid_cfg_r      <= '0;
      hold_target_r  <= '0;
      run_mode_r     <= '0;
      track_length_r <= '0;
      track_pos_r    <= '0;
      track_done_r   <= 1'b0;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (track_go) begin
        track_pos_r <= track_pos_r + 11'd1;
      end else if (is_tick && (run_mode_r == ppt_pkg::MODE_TRACK) && walk_end) begin
        track_done_r <= 1'b1;
      end
      if (cfg_acc) begin
        case (cfg_index)
          ppt_pkg::REG_GAIN_PROP:    pid_cfg_r.kp     <= cfg_data;
          ppt_pkg::REG_GAIN_INTEG:   pid_cfg_r.ki     <= cfg_data;
          ppt_pkg::REG_GAIN_DERIV:   pid_cfg_r.kd     <= cfg_data;
          ppt_pkg::REG_HOLD_TARGET:  hold_target_r    <= cfg_data;
          ppt_pkg::REG_RUN_MODE: begin
            run_mode_r   <= cfg_data[1:0];
            track_pos_r  <= '0;
            track_done_r <= 1'b0;
          end
          ppt_pkg::REG_TRACK_LENGTH: track_length_r   <= cfg_data[10:0];
          ppt_pkg::REG_PWM_PERIOD:   pid_cfg_r.period <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_r <= enc_in;
    end
    if (state_r == S_REF) begin
      ref_r <= ref_now;
    end
    if (out_load) begin
      out_tdata_r <= OUT_TDATA_W'({pos_r, ref_r, pid_cmp, pid_mag, pid_dir, pid_drive});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

@@ src/ppt_checker.sv @@
// Port-level assertion checker for the position tracker and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module ppt_checker #(
  parameter int DRIVE_LIMIT = ppt_pkg::DRIVE_LIMIT_DEF,
  localparam int OUT_W       = ppt_pkg::out_width(DRIVE_LIMIT),
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int MAG_W = ppt_pkg::mag_width(DRIVE_LIMIT);
  localparam int DRV_W = MAG_W + 1;

  logic [DRV_W-1:0] drv;
  logic             dir;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] abs_drv;

  assign drv     = out_tdata[DRV_W-1:0];
  assign dir     = out_tdata[DRV_W];
  assign mag     = out_tdata[DRV_W+MAG_W:DRV_W+1];
  assign abs_drv = drv[DRV_W-1] ? MAG_W'(-drv) : MAG_W'(drv);

  `PPT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `PPT_ASSERT(a_drive_fields, !out_tvalid || ((dir == drv[DRV_W-1]) && (mag == abs_drv)), "direction or magnitude disagrees with drive")
  `PPT_ASSERT(a_drive_limit, !out_tvalid || (32'(mag) <= DRIVE_LIMIT), "drive magnitude beyond limit")
  `PPT_ASSERT_NEXT(a_load_quiet, in_tvalid && in_tready && in_tuser && !out_tvalid, !out_tvalid, "load request produced a result")

endmodule

bind pid_position_tracker ppt_checker #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_ppt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
